### sv/udf_pkg.sv
// Package with the types and constants of the unsigned decimal formatter.
`default_nettype none
package udf_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned FIELD_W  = 6;
    localparam int unsigned NUM_DIGS = 10;
    localparam int unsigned DIG_W    = 4;
    localparam int unsigned BITCNT_W = 5;
    localparam int unsigned IN_DW    = 48;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned OUT_DW   = 40;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

### sv/unsigned_decimal_formatter.sv
// Formats a 32-bit unsigned value as padded ASCII decimal text, one character per beat.
// An input beat is loaded, converted by a bit-serial binary to BCD shift loop and then sized
// before the first character; the input is not ready for a new item until the last character
// of the field (1 to MAX_FIELD) is issued, one character per cycle while the output accepts.
// Reset: synchronous, active low; clears the state machine, output valid and the
// running character count.
`default_nettype none
module unsigned_decimal_formatter
    import udf_pkg::*;
#(
    parameter int unsigned MAX_FIELD = 48
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // value[31:0], field_width[37:32], precision[43:38], has_precision[44],
    // left_justify[45], zero_pad[46], bit 47 unused
    input  wire logic [IN_DW-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    // char_out[7:0], total_written[39:8]
    output logic [OUT_DW-1:0]      o_m_axis_tdata,
    output logic                   o_m_axis_tlast
);

    localparam int unsigned CW  = $clog2(MAX_FIELD + 1);
    localparam int unsigned CW2 = (CW > FIELD_W) ? CW : FIELD_W;

    t_state r_state, n_state;

    logic [VALUE_W-1:0]  r_bin, n_bin;
    logic [DIG_W-1:0]    r_bcd [NUM_DIGS];
    logic [DIG_W-1:0]    n_bcd [NUM_DIGS];
    logic [BITCNT_W-1:0] r_bit_cnt, n_bit_cnt;
    logic [CW-1:0]       r_width, n_width;
    logic [CW-1:0]       r_prec, n_prec;
    logic                r_left, n_left;
    logic                r_zpad, n_zpad;
    logic [CW-1:0]       r_pad, n_pad;
    logic [CW-1:0]       r_zero, n_zero;
    logic [DIG_W-1:0]    r_dig, n_dig;
    logic [CW-1:0]       r_rem, n_rem;
    logic [VALUE_W-1:0]  r_total, n_total;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_char, n_out_char;
    logic                r_out_last, n_out_last;
    logic [VALUE_W-1:0]  r_out_count, n_out_count;

    logic [DIG_W-1:0]    w_adj [NUM_DIGS];
    logic [CW2-1:0]      w_width_ext;
    logic [CW2-1:0]      w_prec_ext;
    logic [DIG_W-1:0]    w_ndig;
    logic [CW-1:0]       w_ndig_ext;
    logic [CW-1:0]       w_body;
    logic [CW-1:0]       w_field;
    logic [DIG_W-1:0]    w_digit;
    logic                w_load;
    logic                w_accept;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load          = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_count, r_out_char};
    assign o_m_axis_tlast  = r_out_last;

    always_comb begin
        for (int k = 0; k < NUM_DIGS; k++) begin
            w_adj[k] = (r_bcd[k] >= DIG_W'(5)) ? r_bcd[k] + DIG_W'(3) : r_bcd[k];
        end
        w_ndig = DIG_W'(1);
        for (int k = 0; k < NUM_DIGS; k++) begin
            if (r_bcd[k] != '0) begin
                w_ndig = DIG_W'(k + 1);
            end
        end
        w_digit = '0;
        for (int k = 0; k < NUM_DIGS; k++) begin
            if (r_dig == DIG_W'(k + 1)) begin
                w_digit = r_bcd[k];
            end
        end
    end

    assign w_width_ext = CW2'(i_s_axis_tdata[37:32]);
    assign w_prec_ext  = CW2'(i_s_axis_tdata[43:38]);
    assign w_ndig_ext  = CW'(w_ndig);
    assign w_body      = (r_prec > w_ndig_ext) ? r_prec : w_ndig_ext;
    assign w_field     = (r_width > w_body) ? r_width : w_body;

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_bit_cnt   = r_bit_cnt;
        n_width     = r_width;
        n_prec      = r_prec;
        n_left      = r_left;
        n_zpad      = r_zpad;
        n_pad       = r_pad;
        n_zero      = r_zero;
        n_dig       = r_dig;
        n_rem       = r_rem;
        n_total     = r_total;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_count = r_out_count;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_bin     = i_s_axis_tdata[31:0];
                    for (int k = 0; k < NUM_DIGS; k++) begin
                        n_bcd[k] = '0;
                    end
                    n_bit_cnt = '0;
                    n_width   = (w_width_ext > CW2'(MAX_FIELD)) ? CW'(MAX_FIELD)
                                                                : CW'(w_width_ext);
                    if (!i_s_axis_tdata[44]) begin
                        n_prec = '0;
                    end else begin
                        n_prec = (w_prec_ext > CW2'(MAX_FIELD)) ? CW'(MAX_FIELD)
                                                                : CW'(w_prec_ext);
                    end
                    n_left    = i_s_axis_tdata[45];
                    n_zpad    = i_s_axis_tdata[46] && !i_s_axis_tdata[45]
                                && !i_s_axis_tdata[44];
                    n_state   = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd[0] = {w_adj[0][2:0], r_bin[VALUE_W-1]};
                for (int k = 1; k < NUM_DIGS; k++) begin
                    n_bcd[k] = {w_adj[k][2:0], w_adj[k-1][3]};
                end
                n_bin     = {r_bin[VALUE_W-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt + BITCNT_W'(1);
                if (r_bit_cnt == '1) begin
                    n_state = ST_SIZE;
                end
            end
            ST_SIZE: begin
                n_dig   = w_ndig;
                n_zero  = w_body - w_ndig_ext;
                n_pad   = w_field - w_body;
                n_rem   = w_field;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_total     = r_total + VALUE_W'(1);
                    n_out_count = r_total + VALUE_W'(1);
                    n_out_last  = (r_rem == CW'(1));
                    n_rem       = r_rem - CW'(1);
                    if (!r_left && (r_pad != '0)) begin
                        n_out_char = r_zpad ? ASCII_ZERO : ASCII_SPACE;
                        n_pad      = r_pad - CW'(1);
                    end else if (r_zero != '0) begin
                        n_out_char = ASCII_ZERO;
                        n_zero     = r_zero - CW'(1);
                    end else if (r_dig != '0) begin
                        n_out_char = ASCII_ZERO + CHAR_W'(w_digit);
                        n_dig      = r_dig - DIG_W'(1);
                    end else begin
                        n_out_char = ASCII_SPACE;
                        n_pad      = r_pad - CW'(1);
                    end
                    if (r_rem == CW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_total     <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin       <= n_bin;
        r_bcd       <= n_bcd;
        r_bit_cnt   <= n_bit_cnt;
        r_width     <= n_width;
        r_prec      <= n_prec;
        r_left      <= n_left;
        r_zpad      <= n_zpad;
        r_pad       <= n_pad;
        r_zero      <= n_zero;
        r_dig       <= n_dig;
        r_rem       <= n_rem;
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
        r_out_count <= n_out_count;
    end

endmodule
`default_nettype wire

### test/tb.sv
// Testbench for the unsigned decimal formatter: random and directed fields checked per character.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import udf_pkg::*;

    localparam int unsigned FIELD_MAX  = 48;
    localparam int unsigned CYCLE_CAP  = 400000;
    localparam int unsigned HOLD_LEN   = 500;
    localparam int unsigned RAND_ITEMS = 350;

    class char_scoreboard;
        typedef struct packed {
            logic [CHAR_W-1:0]  ch;
            logic               last;
            logic [VALUE_W-1:0] total;
        } t_char_beat;

        t_char_beat         expected_chars[$];
        logic [VALUE_W-1:0] chars_emitted;
        int unsigned        mismatches;

        function new();
            chars_emitted = '0;
            mismatches    = 0;
        endfunction

        function int unsigned pending();
            return expected_chars.size();
        endfunction

        function void note_item(input logic [IN_DW-1:0] beat);
            logic [VALUE_W-1:0] v;
            int unsigned        width;
            int unsigned        prec;
            int unsigned        ndig;
            int unsigned        nbody;
            int unsigned        span;
            int unsigned        pad;
            int unsigned        i;
            bit                 hp;
            bit                 lj;
            bit                 zp;
            logic [CHAR_W-1:0]  digs [NUM_DIGS];
            logic [CHAR_W-1:0]  text [$];
            t_char_beat         exp_beat;

            v     = beat[31:0];
            width = 32'(beat[37:32]);
            prec  = 32'(beat[43:38]);
            hp    = beat[44];
            lj    = beat[45];
            zp    = beat[46] && !lj && !hp;
            if (width > FIELD_MAX) width = FIELD_MAX;
            if (prec > FIELD_MAX) prec = FIELD_MAX;

            ndig = 0;
            do begin
                digs[ndig] = ASCII_ZERO + CHAR_W'(v % 10);
                ndig++;
                v = v / 10;
            end while (v != 0 && ndig < NUM_DIGS);

            nbody = ndig;
            if (hp && prec > nbody) nbody = prec;
            span = (width > nbody) ? width : nbody;
            if (span > FIELD_MAX) span = FIELD_MAX;
            pad = span - nbody;

            if (!lj) begin
                for (i = 0; i < pad; i++) text.push_back(zp ? ASCII_ZERO : ASCII_SPACE);
            end
            for (i = ndig; i < nbody; i++) text.push_back(ASCII_ZERO);
            for (i = ndig; i > 0; i--) text.push_back(digs[i-1]);
            if (lj) begin
                for (i = 0; i < pad; i++) text.push_back(ASCII_SPACE);
            end

            for (i = 0; i < text.size(); i++) begin
                chars_emitted  = chars_emitted + 1;
                exp_beat.ch    = text[i];
                exp_beat.last  = (i + 1 == text.size());
                exp_beat.total = chars_emitted;
                expected_chars.push_back(exp_beat);
            end
        endfunction

        function void check_char(input logic [CHAR_W-1:0] ch, input logic last,
                                 input logic [VALUE_W-1:0] total);
            t_char_beat exp_beat;

            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected beat char=%h last=%b total=%h", ch, last, total);
                return;
            end
            exp_beat = expected_chars.pop_front();
            if (exp_beat.ch !== ch || exp_beat.last !== last || exp_beat.total !== total) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"tb: mismatch expected char=%h last=%b total=%h, ",
                              "got char=%h last=%b total=%h"},
                             exp_beat.ch, exp_beat.last, exp_beat.total, ch, last, total);
            end
        endfunction
    endclass

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               s_tvalid        = 1'b0;
    logic [IN_DW-1:0]   s_tdata         = '0;
    logic               m_tready        = 1'b0;
    logic               o_s_axis_tready;
    logic               o_m_axis_tvalid;
    logic [OUT_DW-1:0]  o_m_axis_tdata;
    logic               o_m_axis_tlast;

    char_scoreboard     sb = new();
    int unsigned        cycle_count = 0;
    bit                 hold_req    = 1'b0;
    int unsigned        hold_left   = 0;

    unsigned_decimal_formatter #(
        .MAX_FIELD (FIELD_MAX)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready)
            sb.check_char(o_m_axis_tdata[7:0], o_m_axis_tlast, o_m_axis_tdata[39:8]);
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_LEN;
            m_tready <= 1'b0;
        end else begin
            case ((cycle_count / 300) % 4)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                2: m_tready <= ((cycle_count % 4) == 0);
                default: m_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    function automatic logic [IN_DW-1:0] pack_item(input logic [31:0] value,
                                                   input logic [5:0] width,
                                                   input logic [5:0] prec,
                                                   input bit hp, input bit lj, input bit zp);
        return {1'b0, zp, lj, hp, prec, width, value};
    endfunction

    function automatic logic [IN_DW-1:0] random_item();
        int unsigned        ndigits;
        logic [31:0]        value;
        logic [31:0]        limit;
        logic [5:0]         width;
        logic [5:0]         prec;
        int unsigned        k;

        ndigits = $urandom_range(0, 10);
        if (ndigits == 10) begin
            value = $urandom();
        end else begin
            limit = 1;
            for (k = 0; k < ndigits; k++) limit = limit * 10;
            value = $urandom() % limit;
        end
        width = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 14));
        prec  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 12));
        return pack_item(value, width, prec, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_item(input logic [IN_DW-1:0] beat);
        s_tdata  <= beat;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_item(beat);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int unsigned cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    initial begin
        logic [IN_DW-1:0] directed [$];
        int unsigned      sent;
        int unsigned      burst;
        int unsigned      idx;

        directed.push_back(pack_item(32'd0, 6'd0, 6'd0, 0, 0, 0));
        directed.push_back(pack_item(32'd0, 6'd0, 6'd0, 1, 0, 0));
        directed.push_back(pack_item(32'hFFFF_FFFF, 6'd0, 6'd0, 0, 0, 0));
        directed.push_back(pack_item(32'hFFFF_FFFF, 6'd12, 6'd0, 0, 0, 1));
        directed.push_back(pack_item(32'd5, 6'd63, 6'd0, 0, 0, 0));
        directed.push_back(pack_item(32'd7, 6'd0, 6'd63, 1, 0, 0));
        directed.push_back(pack_item(32'd123, 6'd63, 6'd63, 1, 1, 1));
        directed.push_back(pack_item(32'd42, 6'd8, 6'd0, 0, 0, 1));
        directed.push_back(pack_item(32'd42, 6'd8, 6'd0, 0, 1, 1));
        directed.push_back(pack_item(32'd42, 6'd8, 6'd3, 1, 0, 1));
        directed.push_back(pack_item(32'd42, 6'd0, 6'd5, 0, 0, 0));
        directed.push_back(pack_item(32'd123, 6'd10, 6'd0, 0, 1, 0));
        directed.push_back(pack_item(32'd99, 6'd5, 6'd12, 1, 0, 0));
        directed.push_back(pack_item(32'd31, 6'd48, 6'd0, 0, 0, 0));
        directed.push_back(pack_item(32'd31, 6'd0, 6'd48, 1, 1, 0));
        directed.push_back(pack_item(32'd1000000000, 6'd0, 6'd0, 0, 0, 0));
        directed.push_back(pack_item(32'd9, 6'd1, 6'd1, 1, 0, 0));
        directed.push_back(pack_item(32'd10, 6'd2, 6'd0, 0, 0, 1));
        directed.push_back(pack_item(32'd4000000000, 6'd1, 6'd0, 0, 1, 0));
        directed.push_back(pack_item(32'd0, 6'd63, 6'd0, 0, 0, 1));
        directed.push_back(pack_item(32'hFFFF_FFFF, 6'd63, 6'd0, 0, 1, 0));
        directed.push_back(pack_item(32'd0, 6'd49, 6'd49, 1, 0, 1));

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        foreach (directed[i]) begin
            send_item(directed[i]);
            idle_gap($urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0);
        end

        sent = 0;
        while (sent < RAND_ITEMS) begin
            burst = $urandom_range(1, 8);
            for (idx = 0; idx < burst && sent < RAND_ITEMS; idx++) begin
                send_item(random_item());
                sent++;
                if (sent == 100) hold_req = 1'b1;
            end
            idle_gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 60));
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
